// ===== rtl/core/lpht_pkg.sv =====
// Package for the linear probe hash table: opcodes, status codes, widths.
// No dependencies.
`default_nettype none
package lpht_pkg;
  localparam int KeyW = 32;
  localparam int SizeW = 9;
  localparam int FuncW = 2;
  localparam int StatW = 2;

  localparam logic [FuncW-1:0] FuncSet = 2'd0;
  localparam logic [FuncW-1:0] FuncGet = 2'd1;
  localparam logic [FuncW-1:0] FuncDel = 2'd2;
  localparam logic [FuncW-1:0] FuncNop = 2'd3;

  localparam logic [StatW-1:0] StOk = 2'd0;
  localparam logic [StatW-1:0] StKeyZero = 2'd1;
  localparam logic [StatW-1:0] StOverflow = 2'd2;
  localparam logic [StatW-1:0] StAbsent = 2'd3;
endpackage
`default_nettype wire

// ===== rtl/core/lpht_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module lpht_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/core/lpht_mod.sv =====
// Multicycle key mod n reduction, one quotient bit per cycle (restoring).
// Depends on lpht_pkg.
`default_nettype none
module lpht_mod import lpht_pkg::*; #(
  parameter int IdxW = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [KeyW-1:0]   key_i,
  input  wire logic [IdxW:0]     n_i,
  output logic                   done_o,
  output logic      [IdxW-1:0]   rem_o
);
  localparam int CntW = $clog2(KeyW + 1);
  logic [KeyW-1:0] sh_q, sh_d;
  logic [IdxW:0] rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [IdxW+1:0] trial;

  assign trial = {rem_q, sh_q[KeyW-1]};

  always_comb begin
    sh_d = sh_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      sh_d = key_i;
      rem_d = '0;
      cnt_d = CntW'(KeyW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      sh_d = {sh_q[KeyW-2:0], 1'b0};
      if (trial >= {1'b0, n_i}) begin
        rem_d = (IdxW+1)'(trial - {1'b0, n_i});
      end else begin
        rem_d = trial[IdxW:0];
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    rem_q <= rem_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign rem_o = rem_d[IdxW-1:0];
endmodule
`default_nettype wire

// ===== rtl/core/linear_probe_hash_table.sv =====
// Linear probe hash table: keys and values in two single-port RAMs.
// A lookup first reduces the key mod the slot count, then probes slots in turn; key zero
// or a nop answers without either. A delete repair scans the slots after the freed one,
// runs a lookup for each occupied one and moves the entry where that lookup ends elsewhere.
// One item at a time; the next beat is taken once the result sits in the output register.
// Reset: a pass over every address zeroes the key RAM; table_size resets to 256, written when idle.
// Depends on lpht_pkg, lpht_ram, lpht_mod.
`default_nettype none
module linear_probe_hash_table import lpht_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_PROBE = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // func[1:0], key[33:2], value[65:34]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // status[1:0], value_res[33:2]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data        // table_size
);
  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = $clog2(MAX_PROBE + 1) + 1;

  // sequencer states
  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_MOD = 4'd2, S_RD = 4'd3,
    S_CHK = 4'd4, S_OUT = 4'd5, S_RSTEP = 4'd6, S_RRD = 4'd7, S_RCHK = 4'd8,
    S_LMOD = 4'd9, S_LRD = 4'd10, S_LCHK = 4'd11, S_MVRD = 4'd12, S_MVWR = 4'd13;

  logic [3:0] st_q, st_d;
  logic [SizeW-1:0] size_q;
  logic [IdxW:0] n_eff;
  logic [PW-1:0] lim;

  // item registers
  logic [FuncW-1:0] func_q, func_d;
  logic [KeyW-1:0] key_q, key_d, val_q, val_d;
  logic [StatW-1:0] stat_q, stat_d;
  logic [31:0] res_q, res_d;
  logic out_v_q, out_v_d;
  // output beat register, frees the sequencer while a result waits
  logic [StatW-1:0] ostat_q, ostat_d;
  logic [31:0] ores_q, ores_d;
  // probe / repair pointers
  logic [IdxW-1:0] idx_q, idx_d, cur_q, cur_d, tgt_q, tgt_d;
  logic [PW-1:0] pc_q, pc_d, seen_q, seen_d;
  logic [KeyW-1:0] rk_q, rk_d;
  logic [IdxW:0] moves_q, moves_d;

  // memory ports
  logic k_we, v_we;
  logic [IdxW-1:0] k_addr, v_addr;
  logic [KeyW-1:0] k_wd, k_rd;
  logic [VALUE_WIDTH-1:0] v_wd, v_rd;

  logic mod_start, mod_done;
  logic [KeyW-1:0] mod_key;
  logic [IdxW-1:0] mod_rem;

  lpht_ram #(.Width(KeyW), .Depth(DEPTH)) u_keys (
    .clk_i, .we_i(k_we), .addr_i(k_addr), .wdata_i(k_wd), .rdata_o(k_rd));
  lpht_ram #(.Width(VALUE_WIDTH), .Depth(DEPTH)) u_vals (
    .clk_i, .we_i(v_we), .addr_i(v_addr), .wdata_i(v_wd), .rdata_o(v_rd));
  lpht_mod #(.IdxW(IdxW)) u_mod (
    .clk_i, .rst_ni, .start_i(mod_start), .key_i(mod_key), .n_i(n_eff),
    .done_o(mod_done), .rem_o(mod_rem));

  // effective slot count and probe limit
  always_comb begin
    if (size_q == '0) n_eff = (IdxW+1)'(1);
    else if ({23'd0, size_q} > DEPTH) n_eff = (IdxW+1)'(DEPTH);
    else n_eff = (IdxW+1)'(size_q);
    if ({{(32-IdxW-1){1'b0}}, n_eff} < MAX_PROBE) lim = PW'(n_eff);
    else lim = PW'(MAX_PROBE);
  end

  function automatic logic [IdxW-1:0] step(input logic [IdxW-1:0] i, input logic [IdxW:0] n);
    logic [IdxW:0] s;
    s = {1'b0, i} + 1'b1;
    return (s >= n) ? '0 : s[IdxW-1:0];
  endfunction

  assign s_axis_tready = (st_q == S_IDLE);
  // size only changes between items
  assign cfg_ready = (st_q == S_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = {6'd0, ores_q, ostat_q};
  // mod starts only in S_IDLE (new key) or S_RCHK (key just read for repair)
  assign mod_key = (st_q == S_IDLE) ? s_axis_tdata[33:2] : k_rd;

  always_comb begin
    st_d = st_q; func_d = func_q; key_d = key_q; val_d = val_q;
    stat_d = stat_q; res_d = res_q; out_v_d = out_v_q;
    ostat_d = ostat_q; ores_d = ores_q;
    idx_d = idx_q; cur_d = cur_q; tgt_d = tgt_q; pc_d = pc_q; seen_d = seen_q;
    rk_d = rk_q; moves_d = moves_q;
    k_we = 1'b0; v_we = 1'b0; k_addr = idx_q; v_addr = idx_q;
    k_wd = '0; v_wd = '0; mod_start = 1'b0;
    if (out_v_q && m_axis_tready) out_v_d = 1'b0;
    case (st_q)
      S_CLR: begin
        k_we = 1'b1; k_addr = idx_q;
        idx_d = idx_q + 1'b1;
        if ({1'b0, idx_q} == (IdxW+1)'(DEPTH - 1)) st_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          func_d = s_axis_tdata[1:0];
          key_d = s_axis_tdata[33:2];
          val_d = s_axis_tdata[65:34];
          res_d = '0;
          stat_d = StOk;
          if (s_axis_tdata[1:0] == FuncNop) st_d = S_OUT;
          else if (s_axis_tdata[33:2] == '0) begin
            stat_d = StKeyZero; st_d = S_OUT;
          end else begin
            mod_start = 1'b1; st_d = S_MOD;
          end
        end
      end
      S_MOD: if (mod_done) begin
        idx_d = mod_rem; pc_d = '0; st_d = S_RD;
      end
      S_RD: begin
        k_addr = idx_q; v_addr = idx_q; st_d = S_CHK;
      end
      S_CHK: begin
        if (k_rd == '0 || k_rd == key_q) begin
          st_d = S_OUT;
          case (func_q)
            FuncSet: begin
              k_we = 1'b1; k_wd = key_q; v_we = 1'b1;
              v_wd = VALUE_WIDTH'({{32{1'b0}}, val_q});
            end
            FuncGet: begin
              if (k_rd == '0) stat_d = StAbsent;
              else res_d = 32'({{32{1'b0}}, v_rd});
            end
            default: begin
              if (k_rd == '0) stat_d = StAbsent;
              else begin
                k_we = 1'b1; cur_d = idx_q; seen_d = '0; moves_d = '0;
                st_d = S_RSTEP;
              end
            end
          endcase
        end else if (pc_q + 1'b1 >= lim) begin
          stat_d = StOverflow; st_d = S_OUT;
        end else begin
          pc_d = pc_q + 1'b1; idx_d = step(idx_q, n_eff); k_addr = idx_d;
          v_addr = idx_d; st_d = S_CHK;
        end
      end
      S_RSTEP: begin
        if (seen_q >= lim) st_d = S_OUT;
        else begin
          cur_d = step(cur_q, n_eff); seen_d = seen_q + 1'b1;
          k_addr = cur_d; st_d = S_RCHK;
        end
      end
      S_RRD: st_d = S_RCHK;
      S_RCHK: begin
        if (k_rd == '0) st_d = S_OUT;
        else begin
          rk_d = k_rd; mod_start = 1'b1; st_d = S_LMOD;
        end
      end
      S_LMOD: if (mod_done) begin
        idx_d = mod_rem; pc_d = '0; st_d = S_LRD;
      end
      S_LRD: begin
        k_addr = idx_q; st_d = S_LCHK;
      end
      S_LCHK: begin
        if (k_rd == '0 || k_rd == rk_q) begin
          if (idx_q == cur_q) st_d = S_RSTEP;
          else if (moves_q >= (IdxW+1)'(DEPTH)) st_d = S_OUT;
          else begin
            tgt_d = idx_q; v_addr = cur_q; st_d = S_MVRD;
          end
        end else if (pc_q + 1'b1 >= lim) st_d = S_RSTEP;
        else begin
          pc_d = pc_q + 1'b1; idx_d = step(idx_q, n_eff); k_addr = idx_d;
          st_d = S_LCHK;
        end
      end
      S_MVRD: begin
        v_addr = cur_q; st_d = S_MVWR;
        // value of the moving entry arrives next cycle
      end
      S_MVWR: begin
        // first cycle: write target key and value
        k_we = 1'b1; k_addr = tgt_q; k_wd = rk_q;
        v_we = 1'b1; v_addr = tgt_q; v_wd = v_rd;
        moves_d = moves_q + 1'b1; seen_d = '0;
        st_d = S_RRD;
        // clear old slot on the following cycle via S_RRD path
        idx_d = cur_q;
      end
      S_OUT: if (!out_v_q || m_axis_tready) begin
        out_v_d = 1'b1; ostat_d = stat_q; ores_d = res_q; st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
    // S_RRD after a move clears the vacated slot, then rescans from it
    if (st_q == S_RRD) begin
      k_we = 1'b1; k_addr = cur_q; k_wd = '0;
      st_d = S_RSTEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; idx_q <= '0; out_v_q <= 1'b0; size_q <= 9'd256;
    end else begin
      st_q <= st_d; idx_q <= idx_d; out_v_q <= out_v_d;
      if (cfg_valid && cfg_ready) size_q <= cfg_data;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d; key_q <= key_d; val_q <= val_d; stat_q <= stat_d;
    res_q <= res_d; cur_q <= cur_d; tgt_q <= tgt_d; pc_q <= pc_d;
    seen_q <= seen_d; rk_q <= rk_d; moves_q <= moves_d;
    ostat_q <= ostat_d; ores_q <= ores_d;
  end
endmodule
`default_nettype wire

// ===== tb/sv/linear_probe_hash_table_tb.sv =====
// Testbench for linear_probe_hash_table: drives set/get/delete beats, predicts results
// with a behavioral hash table, and checks every result beat. Depends on lpht_pkg and the RTL.
`timescale 1ns / 100ps
module linear_probe_hash_table_tb;
  import lpht_pkg::*;

  localparam int Depth = 256;
  localparam int MaxProbe = 16;
  localparam longint CycleLimit = 4000000;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [31:0]      value_res;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = '0;  // func[1:0], key[33:2], value[65:34]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;       // status[1:0], value_res[33:2]
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [8:0] cfg_data = '0;

  always #1 clk_i = ~clk_i;

  linear_probe_hash_table u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Shadow table
  logic [31:0] shadow_keys [Depth];
  logic [31:0] shadow_vals [Depth];
  logic [8:0]  shadow_size;
  result_t     pending_results[$];

  int  send_idle_pct = 0;   // percent of cycles the sender holds off
  int  recv_idle_pct = 0;   // percent of cycles the receiver stalls
  int  hold_off = 0;        // forced receiver stall, in cycles
  int  errors = 0;
  longint cycles = 0;

  function automatic int slots_used();
    int n;
    n = shadow_size;
    if (n == 0) n = 1;
    if (n > Depth) n = Depth;
    return n;
  endfunction

  // first empty or matching slot within probe limit; -1 on overflow
  function automatic int find_slot(logic [31:0] key);
    int n, lim, idx;
    n = slots_used();
    lim = (n < MaxProbe) ? n : MaxProbe;
    idx = key % n;
    for (int i = 0; i < lim; i++) begin
      if (shadow_keys[idx] == 0 || shadow_keys[idx] == key) return idx;
      idx = (idx + 1 >= n) ? 0 : idx + 1;
    end
    return -1;
  endfunction

  // Re-seat entries behind a freed slot so later lookups still reach them.
  function automatic void close_gap(int hole);
    int n, lim, cur, seen, moves, tgt;
    logic [31:0] k;
    n = slots_used();
    lim = (n < MaxProbe) ? n : MaxProbe;
    cur = hole; seen = 0; moves = 0;
    while (seen < lim) begin
      cur = (cur + 1 >= n) ? 0 : cur + 1;
      seen++;
      k = shadow_keys[cur];
      if (k == 0) break;
      tgt = find_slot(k);
      if (tgt < 0 || tgt == cur) continue;
      if (moves >= Depth) break;
      shadow_keys[tgt] = k;
      shadow_vals[tgt] = shadow_vals[cur];
      shadow_keys[cur] = 0;
      shadow_vals[cur] = 0;
      moves++;
      seen = 0;
    end
  endfunction

  function automatic result_t apply_op(logic [1:0] func, logic [31:0] key,
                                       logic [31:0] value);
    result_t r;
    int slot;
    r = '{status: StOk, value_res: '0};
    if (func != FuncSet && func != FuncGet && func != FuncDel) return r;
    if (key == 0) begin
      r.status = StKeyZero;
      return r;
    end
    slot = find_slot(key);
    if (slot < 0) r.status = StOverflow;
    else if (func == FuncSet) begin
      shadow_keys[slot] = key;
      shadow_vals[slot] = value;
    end else if (shadow_keys[slot] == 0) r.status = StAbsent;
    else if (func == FuncGet) r.value_res = shadow_vals[slot];
    else begin
      shadow_keys[slot] = 0;
      shadow_vals[slot] = 0;
      close_gap(slot);
    end
    return r;
  endfunction

  // Send one beat; prediction made at acceptance. tvalid stays up after the
  // beat until the next send or an explicit pause drops it.
  task automatic send_op(logic [1:0] func, logic [31:0] key, logic [31:0] value);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata <= {6'd0, value, key, func};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(apply_op(func, key, value));
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);  // settle before reconfiguring or ending
  endtask

  task automatic set_size(int unsigned sz);
    drain();
    cfg_data <= sz[8:0];
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    shadow_size = sz[8:0];
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Receiver side
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker
  always @(posedge clk_i) begin
    result_t got, exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{status: m_axis_tdata[1:0], value_res: m_axis_tdata[33:2]};
      if (pending_results.size() == 0) begin
        $error("unexpected result beat status=%0d value_res=%h", got.status, got.value_res);
        errors++;
      end else begin
        exp = pending_results.pop_front();
        if (got.status !== exp.status) begin
          $error("status: expected %0d, got %0d", exp.status, got.status);
          errors++;
        end
        if (got.value_res !== exp.value_res) begin
          $error("value_res: expected %h, got %h", exp.value_res, got.value_res);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Mostly a small pool of keys sharing home slots (chains, repairs); some zero or random keys.
  function automatic logic [31:0] pick_key(int n);
    case ($urandom_range(9))
      0: return 32'd0;
      1: return $urandom();
      2: return 32'hFFFF_FFFF - $urandom_range(3);
      default: return $urandom_range(3) * n + $urandom_range(7) + 1;
    endcase
  endfunction

  task automatic run_random(int count);
    int n;
    logic [1:0] f;
    for (int i = 0; i < count; i++) begin
      n = slots_used();
      f = ($urandom_range(19) == 0) ? FuncNop : 2'($urandom_range(2));
      send_op(f, pick_key(n), $urandom());
    end
  endtask

  task automatic test_directed();
    send_op(FuncSet, 32'd0, 32'h1234);           // key zero on each op
    send_op(FuncGet, 32'd0, 32'h0);
    send_op(FuncDel, 32'd0, 32'h0);
    send_op(FuncGet, 32'd5, 32'h0);              // key absent
    send_op(FuncDel, 32'd5, 32'h0);
    send_op(FuncSet, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(FuncGet, 32'hFFFF_FFFF, 32'h0);
    send_op(FuncSet, 32'd5, 32'hA5A5_5A5A);
    send_op(FuncSet, 32'd5, 32'h5A5A_A5A5);      // overwrite
    send_op(FuncGet, 32'd5, 32'h0);
    send_op(FuncNop, 32'd5, 32'hFFFF_FFFF);      // no-op opcode
    send_op(FuncDel, 32'd5, 32'h0);
    send_op(FuncGet, 32'd5, 32'h0);
  endtask

  // Small table: overflow, repair, resizing
  task automatic test_small_table();
    set_size(4);
    for (int k = 1; k <= 5; k++) send_op(FuncSet, 32'(k * 4), 32'(k));
    send_op(FuncGet, 32'd20, 32'h0);             // overflow
    send_op(FuncDel, 32'd4, 32'h0);              // repair pulls chain back
    send_op(FuncGet, 32'd16, 32'h0);
    send_op(FuncGet, 32'd8, 32'h0);
    set_size(0);                                 // acts as one slot
    send_op(FuncSet, 32'd7, 32'd70);
    send_op(FuncGet, 32'd7, 32'h0);
    set_size(2);                                 // slots beyond size kept
    send_op(FuncGet, 32'd12, 32'h0);
  endtask

  task automatic test_random_phases();
    int sizes[6] = '{1, 3, 17, 256, 511, 64};
    for (int p = 0; p < 6; p++) begin
      set_size(sizes[p]);
      send_idle_pct = (p % 3 == 0) ? 10 : (p % 3 == 1) ? 49 : 0;
      recv_idle_pct = (p % 3 == 0) ? 49 : (p % 3 == 1) ? 10 : 0;
      run_random(220);
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
  endtask

  // Receiver holds off while beats keep coming, then sender waits for all.
  task automatic test_backpressure();
    hold_off = 3000;
    run_random(40);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    run_random(40);
  endtask

  initial begin
    for (int i = 0; i < Depth; i++) begin
      shadow_keys[i] = 0;
      shadow_vals[i] = 0;
    end
    shadow_size = 9'd256;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_small_table();
    test_random_phases();
    test_backpressure();
    drain();
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
